// File: sv/fwt_pkg.sv
// ----------------------------------------------------------------------------
// fwt_pkg: shared types and constants of the futex wait/wake table
// Command and status codes, controller states, slot entry layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fwt_pkg;

   typedef enum logic [1:0] {
      CMD_WAIT        = 2'd0,
      CMD_WAKE        = 2'd1,
      CMD_CLEAR       = 2'd2,
      CMD_UNSUPPORTED = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_WOULD_BLOCK = 3'd1,
      ST_TIMED_OUT   = 3'd2,
      ST_MUST_WAIT   = 3'd3,
      ST_TABLE_FULL  = 3'd4,
      ST_UNSUPPORTED = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_NEW,
      S_WFIN,
      S_FINAL
   } state_type;

   typedef struct packed {
      logic [15:0] thread;
      logic [31:0] address;
      logic [31:0] expiry;
      logic        woken;
   } slot_entry_type;

   localparam int unsigned SLOT_W = $bits(slot_entry_type);

   localparam logic [31:0] FAR_LIMIT  = 32'hF000_0000;
   localparam logic [31:0] NO_TIMEOUT = 32'hFFFF_FFFF;
   localparam logic [9:0]  MS_PER_SEC = 10'd1000;
   // ceil(2^50 / 1e6): exact quotient for every 30-bit nanosecond value
   localparam logic [30:0] NANO_RECIP = 31'd1125899907;
   localparam int unsigned NANO_SHIFT = 50;
   localparam logic [5:0]  MAX_WOKEN  = 6'd32;

endpackage

// File: sv/fwt_if.sv
// ----------------------------------------------------------------------------
// fwt_if: request and response channels of the futex wait/wake table
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fwt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] thread_id;
   logic [31:0] address;
   logic [31:0] op_value;
   logic [31:0] current_value;
   logic        has_timeout;
   logic [31:0] timeout_seconds;
   logic [29:0] timeout_nanos;
   logic [31:0] now_ms;
   logic [31:0] wait_start_ms;

   modport source (output valid, command, thread_id, address, op_value, current_value,
                   has_timeout, timeout_seconds, timeout_nanos, now_ms, wait_start_ms,
                   input ready);
   modport sink (input valid, command, thread_id, address, op_value, current_value,
                 has_timeout, timeout_seconds, timeout_nanos, now_ms, wait_start_ms,
                 output ready);
endinterface

interface fwt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] deadline_ms;
   logic        woken_valid;
   logic [15:0] woken_thread;
   logic [5:0]  wake_count;
   logic        last;

   modport source (output valid, status, deadline_ms, woken_valid, woken_thread,
                   wake_count, last, input ready);
   modport sink (input valid, status, deadline_ms, woken_valid, woken_thread,
                 wake_count, last, output ready);
endinterface

// File: sv/fwt_ram.sv
// ----------------------------------------------------------------------------
// fwt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/fwt_expiry.sv
// ----------------------------------------------------------------------------
// fwt_expiry: expiry time of a new wait
// now + seconds*1000 + nanos/1e6, two register stages after the transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwt_expiry (
   input  logic        clock,
   input  logic        load,
   input  logic        has_timeout,
   input  logic [31:0] timeout_seconds,
   input  logic [29:0] timeout_nanos,
   input  logic [31:0] now_ms,
   output logic [31:0] expiry
);
   import fwt_pkg::*;

   logic [31:0] sec_ms_ff;
   logic [60:0] nano_prod_ff;
   logic        has_ff;
   logic [31:0] now_ff;
   logic [31:0] expiry_ff;
   logic [31:0] expiry_in;
   logic [31:0] nano_ms;

   always_ff @(posedge clock) begin
      if (load) begin
         sec_ms_ff    <= 32'(timeout_seconds * {22'd0, MS_PER_SEC});
         nano_prod_ff <= {31'd0, timeout_nanos} * {30'd0, NANO_RECIP};
         has_ff       <= has_timeout;
         now_ff       <= now_ms;
      end
      expiry_ff <= expiry_in;
   end

   always_comb begin
      nano_ms   = {22'd0, nano_prod_ff[NANO_SHIFT +: 10]};
      expiry_in = has_ff ? (sec_ms_ff + nano_ms + now_ff) : NO_TIMEOUT;
   end

   assign expiry = expiry_ff;

endmodule

// File: sv/futex_wait_wake_table.sv
// ----------------------------------------------------------------------------
// futex_wait_wake_table: waiter table keyed by thread and address
// Flow: a command scans the table slot by slot, reading each slot in S_READ and
//    evaluating each used slot in S_EVAL; a WAIT match or WAKE limit may end it.
// Throughput: one item at a time, set by the single read port of the slot RAM.
// Reset clears all slot used bits at once; slot contents stay undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module futex_wait_wake_table #(
   parameter int unsigned TABLE_ENTRIES = 32
) (
   input logic      clock,
   input logic      reset,
   fwt_req_if.sink  req_chan,
   fwt_rsp_if.source rsp_chan
);
   import fwt_pkg::*;

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [TABLE_ENTRIES-1:0] used_ff, used_in;
   command_type cmd_ff, cmd_in;
   logic [15:0] tid_ff, tid_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] opv_ff, opv_in;
   logic [31:0] cur_ff, cur_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] wstart_ff, wstart_in;
   logic        free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [5:0]  count_ff, count_in;
   logic        pend_ff, pend_in;
   logic [15:0] pend_thread_ff, pend_thread_in;
   status_type  fin_status_ff, fin_status_in;

   logic        o_valid_ff, o_valid_in;
   status_type  o_status_ff, o_status_in;
   logic [31:0] o_deadline_ff, o_deadline_in;
   logic        o_wv_ff, o_wv_in;
   logic [15:0] o_wt_ff, o_wt_in;
   logic [5:0]  o_wc_ff, o_wc_in;
   logic        o_last_ff, o_last_in;

   logic           mem_we;
   logic [IDX_W-1:0] mem_waddr;
   slot_entry_type mem_wdata;
   slot_entry_type entry;
   logic [SLOT_W-1:0] rd_bits;
   logic [31:0]    expiry;
   logic           accept;
   logic           emit_ok;
   logic           at_last;
   logic           limit_hit;
   state_type      end_state;
   logic [31:0]    recheck_dl;
   logic [31:0]    new_dl;

   fwt_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_ENTRIES)) u_slots (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (idx_ff),
      .rd_data (rd_bits)
   );

   fwt_expiry u_expiry (
      .clock           (clock),
      .load            (accept),
      .has_timeout     (req_chan.has_timeout),
      .timeout_seconds (req_chan.timeout_seconds),
      .timeout_nanos   (req_chan.timeout_nanos),
      .now_ms          (req_chan.now_ms),
      .expiry          (expiry)
   );

   assign entry  = slot_entry_type'(rd_bits);
   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept  = req_chan.valid && req_chan.ready;
   assign emit_ok = !o_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         used_ff    <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         o_valid_ff <= o_valid_in;
      end
      idx_ff         <= idx_in;
      cmd_ff         <= cmd_in;
      tid_ff         <= tid_in;
      addr_ff        <= addr_in;
      opv_ff         <= opv_in;
      cur_ff         <= cur_in;
      now_ff         <= now_in;
      wstart_ff      <= wstart_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      count_ff       <= count_in;
      pend_ff        <= pend_in;
      pend_thread_ff <= pend_thread_in;
      fin_status_ff  <= fin_status_in;
      o_status_ff    <= o_status_in;
      o_deadline_ff  <= o_deadline_in;
      o_wv_ff        <= o_wv_in;
      o_wt_ff        <= o_wt_in;
      o_wc_ff        <= o_wc_in;
      o_last_ff      <= o_last_in;
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      used_in        = used_ff;
      cmd_in         = cmd_ff;
      tid_in         = tid_ff;
      addr_in        = addr_ff;
      opv_in         = opv_ff;
      cur_in         = cur_ff;
      now_in         = now_ff;
      wstart_in      = wstart_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      count_in       = count_ff;
      pend_in        = pend_ff;
      pend_thread_in = pend_thread_ff;
      fin_status_in  = fin_status_ff;
      o_valid_in     = o_valid_ff && !rsp_chan.ready;
      o_status_in    = o_status_ff;
      o_deadline_in  = o_deadline_ff;
      o_wv_in        = o_wv_ff;
      o_wt_in        = o_wt_ff;
      o_wc_in        = o_wc_ff;
      o_last_in      = o_last_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff;
      mem_wdata      = entry;

      at_last   = (idx_ff == LAST_IDX);
      limit_hit = ({26'd0, count_ff} >= opv_ff) || (count_ff == MAX_WOKEN);
      unique case (cmd_ff)
         CMD_WAIT:  end_state = S_NEW;
         CMD_WAKE:  end_state = S_WFIN;
         default:   end_state = S_FINAL;
      endcase
      recheck_dl = (entry.expiry < FAR_LIMIT) ? (entry.expiry + wstart_ff) : entry.expiry;
      new_dl     = (expiry < FAR_LIMIT) ? (expiry + now_ff) : expiry;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in        = command_type'(req_chan.command);
               tid_in        = req_chan.thread_id;
               addr_in       = req_chan.address;
               opv_in        = req_chan.op_value;
               cur_in        = req_chan.current_value;
               now_in        = req_chan.now_ms;
               wstart_in     = req_chan.wait_start_ms;
               idx_in        = '0;
               free_found_in = 1'b0;
               count_in      = '0;
               pend_in       = 1'b0;
               if (command_type'(req_chan.command) == CMD_UNSUPPORTED) begin
                  fin_status_in = ST_UNSUPPORTED;
                  state_in      = S_FINAL;
               end else begin
                  fin_status_in = ST_OK;
                  state_in      = S_READ;
               end
            end
         end
         S_READ: begin
            if (cmd_ff == CMD_WAKE && limit_hit) begin
               state_in = S_WFIN;
            end else if (!used_ff[idx_ff]) begin
               if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (at_last) begin
                  state_in = end_state;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = at_last ? end_state : S_READ;
            if (!at_last) begin
               idx_in = idx_ff + 1'b1;
            end
            unique case (cmd_ff)
               CMD_WAIT: begin
                  if (entry.thread == tid_ff && entry.address == addr_ff) begin
                     if (emit_ok) begin
                        o_valid_in    = 1'b1;
                        o_deadline_in = '0;
                        o_wv_in       = 1'b0;
                        o_wt_in       = '0;
                        o_wc_in       = '0;
                        o_last_in     = 1'b1;
                        state_in      = S_IDLE;
                        if (entry.woken) begin
                           o_status_in      = ST_OK;
                           used_in[idx_ff]  = 1'b0;
                        end else if (entry.expiry <= now_ff) begin
                           o_status_in      = ST_TIMED_OUT;
                           used_in[idx_ff]  = 1'b0;
                        end else begin
                           o_status_in   = ST_MUST_WAIT;
                           o_deadline_in = recheck_dl;
                        end
                     end else begin
                        state_in = S_EVAL;
                        idx_in   = idx_ff;
                     end
                  end
               end
               CMD_WAKE: begin
                  if (entry.address == addr_ff && !entry.woken) begin
                     if (!pend_ff || emit_ok) begin
                        if (pend_ff) begin
                           o_valid_in    = 1'b1;
                           o_status_in   = ST_OK;
                           o_deadline_in = '0;
                           o_wv_in       = 1'b1;
                           o_wt_in       = pend_thread_ff;
                           o_wc_in       = count_ff;
                           o_last_in     = 1'b0;
                        end
                        pend_in         = 1'b1;
                        pend_thread_in  = entry.thread;
                        count_in        = count_ff + 1'b1;
                        mem_we          = 1'b1;
                        mem_wdata.woken = 1'b1;
                     end else begin
                        state_in = S_EVAL;
                        idx_in   = idx_ff;
                     end
                  end
               end
               default: begin
                  if (entry.thread == tid_ff) begin
                     used_in[idx_ff] = 1'b0;
                  end
               end
            endcase
         end
         S_NEW: begin
            if (emit_ok) begin
               o_valid_in    = 1'b1;
               o_deadline_in = '0;
               o_wv_in       = 1'b0;
               o_wt_in       = '0;
               o_wc_in       = '0;
               o_last_in     = 1'b1;
               state_in      = S_IDLE;
               if (cur_ff != opv_ff) begin
                  o_status_in = ST_WOULD_BLOCK;
               end else if (free_found_ff) begin
                  o_status_in            = ST_MUST_WAIT;
                  o_deadline_in          = new_dl;
                  used_in[free_idx_ff]   = 1'b1;
                  mem_we                 = 1'b1;
                  mem_waddr              = free_idx_ff;
                  mem_wdata.thread       = tid_ff;
                  mem_wdata.address      = addr_ff;
                  mem_wdata.expiry       = expiry;
                  mem_wdata.woken        = 1'b0;
               end else begin
                  o_status_in = ST_TABLE_FULL;
               end
            end
         end
         S_WFIN: begin
            if (emit_ok) begin
               o_valid_in    = 1'b1;
               o_status_in   = ST_OK;
               o_deadline_in = '0;
               o_wv_in       = pend_ff;
               o_wt_in       = pend_ff ? pend_thread_ff : '0;
               o_wc_in       = count_ff;
               o_last_in     = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            if (emit_ok) begin
               o_valid_in    = 1'b1;
               o_status_in   = fin_status_ff;
               o_deadline_in = '0;
               o_wv_in       = 1'b0;
               o_wt_in       = '0;
               o_wc_in       = '0;
               o_last_in     = 1'b1;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   assign rsp_chan.valid        = o_valid_ff;
   assign rsp_chan.status       = o_status_ff;
   assign rsp_chan.deadline_ms  = o_deadline_ff;
   assign rsp_chan.woken_valid  = o_wv_ff;
   assign rsp_chan.woken_thread = o_wt_ff;
   assign rsp_chan.wake_count   = o_wc_ff;
   assign rsp_chan.last         = o_last_ff;

endmodule
